@@ design/assert_macros.svh @@
// Assertion macros shared by the wheel mixer RTL.
// Needs clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define WMN_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wheel mixer assertion failed");

// next-cycle implication, off while in reset
`define WMN_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wheel mixer assertion failed");

`endif

@@ design/wmn_pkg.sv @@
// Types and constants of the wheel mixer normalizer.
// No dependencies; used by wheel_mixer_normalizer_unit.
package wmn_pkg;

	localparam int FRAC_BITS  = 14;
	localparam int VEL_W      = 16;
	localparam int WHEEL_W    = 16;
	localparam int COUNT_W    = 3;
	localparam int MODE_W     = 3;
	localparam int NUM_WHEELS = 4;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam int SUM_W = VEL_W + 2;
	localparam int MAG_W = VEL_W + 1;
	localparam int REM_W = MAG_W + 1;
	localparam int QUO_W = FRAC_BITS + 1;
	localparam int NDIV  = FRAC_BITS + 1;

	localparam int ONE_INT = 1 << FRAC_BITS;

	localparam logic signed [WHEEL_W-1:0] WHEEL_MAX = WHEEL_W'(ONE_INT);
	localparam logic signed [WHEEL_W-1:0] WHEEL_MIN = WHEEL_W'(-ONE_INT);

	localparam logic [PADDR_W-3:0] REG_MIX_MODE = '0;

	typedef enum logic [MODE_W-1:0] {
		MODE_NONE    = 3'd0,
		MODE_MECANUM = 3'd1,
		MODE_PARL4   = 3'd2,
		MODE_PARL2   = 3'd3,
		MODE_SINGLE  = 3'd4
	} mix_mode_t;

	typedef struct packed {
		logic signed [VEL_W-1:0] vel_x;
		logic signed [VEL_W-1:0] vel_y;
		logic signed [VEL_W-1:0] yaw_rate;
	} vec_word_t;

	typedef struct packed {
		logic signed [WHEEL_W-1:0] wheel_a;
		logic signed [WHEEL_W-1:0] wheel_b;
		logic signed [WHEEL_W-1:0] wheel_c;
		logic signed [WHEEL_W-1:0] wheel_d;
		logic [COUNT_W-1:0]        wheel_count;
		logic                      was_scaled;
	} drive_word_t;

endpackage

@@ design/wheel_mixer_normalizer_unit.sv @@
// Wheel mixer normalizer: mixes a chassis move vector into four wheel drive words.
// Depends on wmn_pkg and assert_macros.svh.
//
// Takes one move word per cycle and gives one drive word per cycle while
// drive_stall is low. Each word passes the mix, magnitude and maximum
// stages, then one restoring-division stage per quotient bit
// (FRAC_BITS + 1 of them, four lanes each), then the output register. Empty
// stages close up while the output is stalled. mix_mode is set over APB at
// byte address 0; codes 5 to 7 act as mode none.
`include "assert_macros.svh"

module wheel_mixer_normalizer_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [wmn_pkg::PADDR_W-1:0]  paddr,
	input  logic [wmn_pkg::PDATA_W-1:0]  pwdata,
	output logic [wmn_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         vec_valid,
	output logic                         vec_stall,
	input  wmn_pkg::vec_word_t           vec_word,
	output logic                         drive_valid,
	input  logic                         drive_stall,
	output wmn_pkg::drive_word_t         drive_word
);
	import wmn_pkg::*;

	typedef struct packed {
		logic [NUM_WHEELS-1:0]              neg;
		logic [NUM_WHEELS-1:0][MAG_W-1:0]   mag;
		logic [NUM_WHEELS-1:0][REM_W-1:0]   rem;
		logic [NUM_WHEELS-1:0][QUO_W-1:0]   quo;
		logic [MAG_W-1:0]                   dmax;
		logic [COUNT_W-1:0]                 count;
		logic                               scaled;
	} div_t;

	function automatic div_t div_step(input div_t x, input logic first);
		div_t                  y;
		logic [REM_W-1:0]      trial;
		logic [REM_W-1:0]      dv;
		y  = x;
		dv = REM_W'(x.dmax);
		for (int k = 0; k < NUM_WHEELS; k++) begin
			trial = first ? x.rem[k] : (x.rem[k] << 1);
			if (trial >= dv) begin
				y.rem[k] = trial - dv;
				y.quo[k] = {x.quo[k][QUO_W-2:0], 1'b1};
			end else begin
				y.rem[k] = trial;
				y.quo[k] = {x.quo[k][QUO_W-2:0], 1'b0};
			end
		end
		return y;
	endfunction

	// configuration
	logic [MODE_W-1:0] mode_q;
	logic              reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[PADDR_W-1:2] == REG_MIX_MODE);
	assign prdata  = reg_hit ? PDATA_W'(mode_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NONE;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			mode_q <= pwdata[MODE_W-1:0];
		end
	end

	// pipeline registers
	logic                                   mix_v_s1;
	logic signed [NUM_WHEELS-1:0][SUM_W-1:0] mix_w_s1;
	logic [COUNT_W-1:0]                     mix_cnt_s1;

	logic                                   mag_v_s2;
	logic [NUM_WHEELS-1:0]                  mag_neg_s2;
	logic [NUM_WHEELS-1:0][MAG_W-1:0]       mag_s2;
	logic [COUNT_W-1:0]                     mag_cnt_s2;

	logic                                   max_v_s3;
	div_t                                   max_s3;

	logic [NDIV-1:0]                        div_v_s4;
	div_t                                   div_s4 [NDIV];
	div_t                                   div_in [NDIV];

	logic                                   drive_v_q;
	drive_word_t                            drive_word_q;

	// stage enables: a stage loads when empty or when its successor loads
	logic                                   en_out;
	logic [NDIV-1:0]                        en_div;
	logic                                   en_s3;
	logic                                   en_s2;
	logic                                   en_s1;

	assign en_out = !drive_v_q || !drive_stall;
	assign en_div[NDIV-1] = !div_v_s4[NDIV-1] || en_out;
	for (genvar j = 0; j < NDIV - 1; j++) begin : g_en
		assign en_div[j] = !div_v_s4[j] || en_div[j+1];
	end
	assign en_s3 = !max_v_s3 || en_div[0];
	assign en_s2 = !mag_v_s2 || en_s3;
	assign en_s1 = !mix_v_s1 || en_s2;

	assign vec_stall   = !en_s1;
	assign drive_valid = drive_v_q;
	assign drive_word  = drive_word_q;

	// stage 1: mix
	logic signed [SUM_W-1:0]                  vx;
	logic signed [SUM_W-1:0]                  vy;
	logic signed [SUM_W-1:0]                  wz;
	logic signed [NUM_WHEELS-1:0][SUM_W-1:0]  mix_w;
	logic [COUNT_W-1:0]                       mix_cnt;

	assign vx = SUM_W'(vec_word.vel_x);
	assign vy = SUM_W'(vec_word.vel_y);
	assign wz = SUM_W'(vec_word.yaw_rate);

	always_comb begin
		mix_w   = '0;
		mix_cnt = '0;
		unique case (mode_q)
			MODE_MECANUM: begin
				mix_w[0] = vx - vy + wz;
				mix_w[1] = vx + vy + wz;
				mix_w[2] = -vx + vy + wz;
				mix_w[3] = -vx - vy + wz;
				mix_cnt  = COUNT_W'(4);
			end
			MODE_PARL4: begin
				mix_w[0] = -vy;
				mix_w[1] = vy;
				mix_w[2] = vy;
				mix_w[3] = -vy;
				mix_cnt  = COUNT_W'(4);
			end
			MODE_PARL2: begin
				mix_w[0] = -vx;
				mix_w[1] = vx;
				mix_cnt  = COUNT_W'(2);
			end
			MODE_SINGLE: begin
				mix_w[0] = vy;
				mix_cnt  = COUNT_W'(1);
			end
			default: begin
				mix_w   = '0;
				mix_cnt = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_v_s1 <= 1'b0;
		end else if (en_s1) begin
			mix_v_s1 <= vec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			mix_w_s1   <= mix_w;
			mix_cnt_s1 <= mix_cnt;
		end
	end

	// stage 2: sign and magnitude
	logic [NUM_WHEELS-1:0]              mag_neg;
	logic [NUM_WHEELS-1:0][MAG_W-1:0]   mag;

	always_comb begin
		for (int k = 0; k < NUM_WHEELS; k++) begin
			mag_neg[k] = mix_w_s1[k][SUM_W-1];
			mag[k]     = mag_neg[k] ? MAG_W'(-mix_w_s1[k]) : MAG_W'(mix_w_s1[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_v_s2 <= 1'b0;
		end else if (en_s2) begin
			mag_v_s2 <= mix_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			mag_neg_s2 <= mag_neg;
			mag_s2     <= mag;
			mag_cnt_s2 <= mix_cnt_s1;
		end
	end

	// stage 3: largest magnitude
	logic [MAG_W-1:0] max01;
	logic [MAG_W-1:0] max23;
	logic [MAG_W-1:0] max_all;
	div_t             max_d;

	assign max01   = (mag_s2[1] > mag_s2[0]) ? mag_s2[1] : mag_s2[0];
	assign max23   = (mag_s2[3] > mag_s2[2]) ? mag_s2[3] : mag_s2[2];
	assign max_all = (max23 > max01) ? max23 : max01;

	always_comb begin
		max_d        = '0;
		max_d.neg    = mag_neg_s2;
		max_d.mag    = mag_s2;
		for (int k = 0; k < NUM_WHEELS; k++) begin
			max_d.rem[k] = REM_W'(mag_s2[k]);
		end
		max_d.dmax   = max_all;
		max_d.count  = mag_cnt_s2;
		max_d.scaled = (int'(max_all) > ONE_INT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_v_s3 <= 1'b0;
		end else if (en_s3) begin
			max_v_s3 <= mag_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			max_s3 <= max_d;
		end
	end

	// stages 4 on: one quotient bit per stage
	assign div_in[0] = max_s3;
	for (genvar j = 1; j < NDIV; j++) begin : g_div_in
		assign div_in[j] = div_s4[j-1];
	end

	for (genvar j = 0; j < NDIV; j++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s4[j] <= 1'b0;
			end else if (en_div[j]) begin
				div_v_s4[j] <= (j == 0) ? max_v_s3 : div_v_s4[(j == 0) ? 0 : j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en_div[j]) begin
				div_s4[j] <= div_step(div_in[j], (j == 0));
			end
		end
	end

	// output: pick scaled or plain magnitude, apply sign
	div_t                                  fin;
	logic [NUM_WHEELS-1:0][WHEEL_W-1:0]    fin_val;
	drive_word_t                           fin_word;

	assign fin = div_s4[NDIV-1];

	always_comb begin
		for (int k = 0; k < NUM_WHEELS; k++) begin
			fin_val[k] = fin.scaled ? WHEEL_W'(fin.quo[k]) : WHEEL_W'(fin.mag[k]);
			if (fin.neg[k]) begin
				fin_val[k] = -fin_val[k];
			end
		end
		fin_word.wheel_a     = fin_val[0];
		fin_word.wheel_b     = fin_val[1];
		fin_word.wheel_c     = fin_val[2];
		fin_word.wheel_d     = fin_val[3];
		fin_word.wheel_count = fin.count;
		fin_word.was_scaled  = fin.scaled;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_v_q <= 1'b0;
		end else if (en_out) begin
			drive_v_q <= div_v_s4[NDIV-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			drive_word_q <= fin_word;
		end
	end

	`WMN_ASSERT_NOW(a_stall_only_when_full, vec_stall, mix_v_s1 && mag_v_s2 && max_v_s3)
	`WMN_ASSERT_NOW(a_wheel_a_range, drive_valid, drive_word.wheel_a <= WHEEL_MAX && drive_word.wheel_a >= WHEEL_MIN)
	`WMN_ASSERT_NOW(a_scaled_has_wheels, drive_valid && drive_word.was_scaled, drive_word.wheel_count != '0)
	`WMN_ASSERT_NOW(a_unused_wheels_zero, drive_valid && drive_word.wheel_count < COUNT_W'(3), drive_word.wheel_c == '0 && drive_word.wheel_d == '0)
	`WMN_ASSERT_NEXT(a_out_held_on_stall, drive_valid && drive_stall, drive_valid)

endmodule

@@ tb/sv/wheel_mixer_normalizer_unit_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for wheel_mixer_normalizer_unit: move words in, drive words out.
// Needs wmn_pkg; predicts each drive word in a scoreboard class and compares per field.

module wheel_mixer_normalizer_unit_test;
	import wmn_pkg::*;

	localparam int DRIVE_LATENCY   = FRAC_BITS + 4;
	localparam int STALL_MAX       = 18;
	localparam int IDLE_LIMIT      = 2000;
	localparam int DIRECTED_N      = 20;
	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 70;
	localparam int PRINT_CAP       = 60;

	localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
	localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

	class wheel_drive_ledger;
		logic [MODE_W-1:0] mix_sel;
		drive_word_t       due_drives[$];
		int unsigned       errors;
		int unsigned       checked;

		function new();
			mix_sel = MODE_NONE;
			errors  = 0;
			checked = 0;
		endfunction

		function void set_mode(logic [MODE_W-1:0] m);
			mix_sel = m;
		endfunction

		function int unsigned pending();
			return due_drives.size();
		endfunction

		function drive_word_t mix_drive(vec_word_t v);
			longint      vx, vy, wz, peak, m;
			longint      w[NUM_WHEELS];
			int unsigned used;
			drive_word_t d;
			vx = v.vel_x;
			vy = v.vel_y;
			wz = v.yaw_rate;
			for (int i = 0; i < NUM_WHEELS; i++)
				w[i] = 0;
			case (mix_sel)
				MODE_MECANUM: begin
					w[0] = vx - vy + wz;
					w[1] = vx + vy + wz;
					w[2] = -vx + vy + wz;
					w[3] = -vx - vy + wz;
					used = 4;
				end
				MODE_PARL4: begin
					w[0] = -vy;
					w[1] = vy;
					w[2] = vy;
					w[3] = -vy;
					used = 4;
				end
				MODE_PARL2: begin
					w[0] = -vx;
					w[1] = vx;
					used = 2;
				end
				MODE_SINGLE: begin
					w[0] = vy;
					used = 1;
				end
				default: used = 0;
			endcase
			peak = 0;
			for (int i = 0; i < used; i++) begin
				m = (w[i] < 0) ? -w[i] : w[i];
				if (m > peak)
					peak = m;
			end
			d.was_scaled = (peak > ONE_INT);
			if (d.was_scaled) begin
				for (int i = 0; i < used; i++) begin
					m = (w[i] < 0) ? -w[i] : w[i];
					m = (m * ONE_INT) / peak;
					w[i] = (w[i] < 0) ? -m : m;
				end
			end
			d.wheel_a     = WHEEL_W'(w[0]);
			d.wheel_b     = WHEEL_W'(w[1]);
			d.wheel_c     = WHEEL_W'(w[2]);
			d.wheel_d     = WHEEL_W'(w[3]);
			d.wheel_count = COUNT_W'(used);
			return d;
		endfunction

		function void note_vec(vec_word_t v);
			due_drives.push_back(mix_drive(v));
		endfunction

		task report(string msg);
			if (errors < PRINT_CAP)
				$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_drive(drive_word_t got);
			drive_word_t want;
			if (due_drives.size() == 0) begin
				report("drive word with nothing expected");
				return;
			end
			want = due_drives.pop_front();
			checked++;
			if (got.wheel_a !== want.wheel_a)
				report($sformatf("wheel_a got %0d want %0d", got.wheel_a, want.wheel_a));
			if (got.wheel_b !== want.wheel_b)
				report($sformatf("wheel_b got %0d want %0d", got.wheel_b, want.wheel_b));
			if (got.wheel_c !== want.wheel_c)
				report($sformatf("wheel_c got %0d want %0d", got.wheel_c, want.wheel_c));
			if (got.wheel_d !== want.wheel_d)
				report($sformatf("wheel_d got %0d want %0d", got.wheel_d, want.wheel_d));
			if (got.wheel_count !== want.wheel_count)
				report($sformatf("wheel_count got %0d want %0d",
					got.wheel_count, want.wheel_count));
			if (got.was_scaled !== want.was_scaled)
				report($sformatf("was_scaled got %0b want %0b",
					got.was_scaled, want.was_scaled));
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	logic                vec_valid;
	logic                vec_stall;
	vec_word_t           vec_word;
	logic                drive_valid;
	logic                drive_stall;
	drive_word_t         drive_word;

	wheel_drive_ledger   board;
	logic                calm;
	int unsigned         sent;
	int unsigned         mode_writes;
	int unsigned         idle_cycles;
	int unsigned         stall_left;

	wheel_mixer_normalizer_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.vec_valid   (vec_valid),
		.vec_stall   (vec_stall),
		.vec_word    (vec_word),
		.drive_valid (drive_valid),
		.drive_stall (drive_stall),
		.drive_word  (drive_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function vec_word_t mk_vec(int x, int y, int z);
		vec_word_t v;
		v.vel_x    = VEL_W'(x);
		v.vel_y    = VEL_W'(y);
		v.yaw_rate = VEL_W'(z);
		return v;
	endfunction

	function vec_word_t directed_vec(int unsigned n);
		case (n)
			0:  return mk_vec(32767, 32767, 32767);
			1:  return mk_vec(-32768, -32768, -32768);
			2:  return mk_vec(16384, 0, 0);
			3:  return mk_vec(8192, 8192, 1);
			4:  return mk_vec(0, 16384, -32768);
			5:  return mk_vec(32767, -16385, 0);
			6:  return mk_vec(0, -32768, 32767);
			7:  return mk_vec(-32768, 32767, 0);
			8:  return mk_vec(-16384, 0, 32767);
			9:  return mk_vec(16385, -32768, 0);
			10: return mk_vec(-32768, 0, 0);
			11: return mk_vec(32767, 1, -1);
			12: return mk_vec(0, 16384, 0);
			13: return mk_vec(0, -16384, 0);
			14: return mk_vec(32767, 16385, 0);
			15: return mk_vec(0, -32768, 32767);
			16: return mk_vec(32767, -32768, 32767);
			17: return mk_vec(-32768, 32767, -32768);
			18: return mk_vec(32767, 32767, -32768);
			default: return mk_vec(-32768, -32768, 32767);
		endcase
	endfunction

	function logic [MODE_W-1:0] directed_mode(int unsigned n);
		if (n < 4)
			return MODE_MECANUM;
		else if (n < 8)
			return MODE_PARL4;
		else if (n < 12)
			return MODE_PARL2;
		else if (n < 16)
			return MODE_SINGLE;
		else if (n < 18)
			return MODE_NONE;
		else
			return MODE_UNUSED_HI;
	endfunction

	function logic [MODE_W-1:0] phase_mode(int unsigned p);
		case (p)
			0: return MODE_MECANUM;
			1: return MODE_SINGLE;
			2: return MODE_PARL4;
			3: return MODE_UNUSED_HI;
			4: return MODE_PARL2;
			5: return MODE_MECANUM;
			6: return MODE_NONE;
			7: return MODE_UNUSED_LO;
			8: return MODE_PARL4;
			default: return MODE_MECANUM;
		endcase
	endfunction

	function int edge_value();
		case ($urandom_range(0, 7))
			0: return -32768;
			1: return 32767;
			2: return 16384;
			3: return -16384;
			4: return 16385;
			5: return -16385;
			6: return 0;
			default: return 1;
		endcase
	endfunction

	function vec_word_t rand_vec();
		int unsigned kind;
		int          x, y, z;
		kind = $urandom_range(0, 9);
		if (kind < 4) begin
			x = $urandom;
			y = $urandom;
			z = $urandom;
		end else if (kind < 6) begin
			// near 1.0 after mixing
			x = $urandom_range(0, 16) + 8184;
			y = $urandom_range(0, 16) + 8184;
			z = $urandom_range(0, 8) - 4;
			if ($urandom_range(0, 1))
				x = -x;
			if ($urandom_range(0, 1))
				y = -y;
		end else if (kind < 8) begin
			x = $urandom_range(0, 16384) - 8192;
			y = $urandom_range(0, 16384) - 8192;
			z = $urandom_range(0, 16384) - 8192;
		end else begin
			x = edge_value();
			y = edge_value();
			z = edge_value();
		end
		return mk_vec(x, y, z);
	endfunction

	task push_vec(vec_word_t v);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, STALL_MAX);
		repeat (gap) begin
			@(negedge clk);
			vec_valid = 1'b0;
		end
		@(negedge clk);
		vec_valid = 1'b1;
		vec_word  = v;
		@(posedge clk);
		while (vec_stall)
			@(posedge clk);
		board.note_vec(v);
		sent++;
	endtask

	task drain();
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task reg_write(logic [MODE_W-1:0] m);
		logic [PDATA_W-1:0] data;
		data = ($urandom & ~PDATA_W'(7)) | PDATA_W'(m);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {REG_MIX_MODE, 2'b00};
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		board.set_mode(data[MODE_W-1:0]);
		mode_writes++;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task switch_mode(logic [MODE_W-1:0] m);
		@(negedge clk);
		vec_valid = 1'b0;
		drain();
		repeat (DRIVE_LATENCY) @(posedge clk);
		reg_write(m);
	endtask

	// drive side: stall per word, check each accepted word
	initial begin
		drive_stall = 1'b0;
		stall_left  = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (drive_valid && !drive_stall) begin
				board.check_drive(drive_word);
				stall_left = calm ? 0 : $urandom_range(0, STALL_MAX);
			end
			@(negedge clk);
			if (stall_left > 0) begin
				drive_stall = 1'b1;
				stall_left--;
			end else begin
				drive_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((vec_valid && !vec_stall) || (drive_valid && !drive_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		board       = new();
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		vec_valid   = 1'b0;
		vec_word    = '0;
		calm        = 1'b0;
		sent        = 0;
		mode_writes = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int unsigned n = 0; n < DIRECTED_N; n++) begin
			if (n == 0 || directed_mode(n) != directed_mode(n - 1))
				switch_mode(directed_mode(n));
			push_vec(directed_vec(n));
		end

		for (int unsigned p = 0; p < PHASES; p++) begin
			switch_mode(phase_mode(p));
			calm = (p % 3 == 2);
			repeat (ITEMS_PER_PHASE) push_vec(rand_vec());
		end

		@(negedge clk);
		vec_valid = 1'b0;
		calm      = 1'b0;
		drain();
		repeat (DRIVE_LATENCY + 4) @(posedge clk);

		$display("Run covered %0d move words across %0d mode settings, all modes and unused codes.",
			sent, mode_writes);
		$display("Drive words checked: %0d, mismatches: %0d", board.checked, board.errors);
		if (board.errors == 0 && board.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+design
design/wmn_pkg.sv
design/wheel_mixer_normalizer_unit.sv
tb/sv/wheel_mixer_normalizer_unit_test.sv
